FILE: hw/rtl/sfde_pkg.sv
package sfde_pkg;

    // Stream and frame geometry
    localparam int MAX_WIDTH = 256;
    localparam int PIX_W     = 8;
    localparam int COL_W     = 8;
    localparam int ROW_W     = 10;
    localparam int WID_W     = 9;
    localparam int CFG_W     = 10;
    localparam int IDX_W     = 2;

    // Register reset values
    localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(188);
    localparam logic [ROW_W-1:0] HEIGHT_RST = ROW_W'(120);

    // Register indexes on the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2,
        REG_AUTO_MODE      = 2'd3
    } t_reg_idx;

    // Per-pixel bookkeeping that travels with a transaction
    typedef struct packed {
        logic             has_res;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_meta;

    // 3x3 window, entry 3*row + col, row 0 on top, col 2 newest
    typedef logic [8:0][PIX_W-1:0] t_window;

endpackage

FILE: hw/rtl/sfde_scan.sv
module sfde_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_cfg_we,
    input  logic [sfde_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [sfde_pkg::CFG_W-1:0]   i_cfg_data,
    output sfde_pkg::t_meta              o_meta,
    output logic [sfde_pkg::PIX_W-1:0]   o_threshold,
    output logic                         o_auto_mode
);

    logic [sfde_pkg::WID_W-1:0] r_width;
    logic [sfde_pkg::ROW_W-1:0] r_height;
    logic [sfde_pkg::PIX_W-1:0] r_threshold;
    logic                       r_auto;
    logic [sfde_pkg::COL_W-1:0] r_col;
    logic [sfde_pkg::ROW_W-1:0] r_row;
    logic [sfde_pkg::COL_W-1:0] n_col;
    logic [sfde_pkg::ROW_W-1:0] n_row;

    logic [sfde_pkg::WID_W-1:0] w_eff;
    logic [sfde_pkg::WID_W-1:0] col_inc;
    logic [sfde_pkg::ROW_W:0]   row_inc;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= sfde_pkg::WIDTH_RST;
            r_height    <= sfde_pkg::HEIGHT_RST;
            r_threshold <= '0;
            r_auto      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (sfde_pkg::t_reg_idx'(i_cfg_idx))
                sfde_pkg::REG_IMAGE_WIDTH:    r_width     <= i_cfg_data[sfde_pkg::WID_W-1:0];
                sfde_pkg::REG_IMAGE_HEIGHT:   r_height    <= i_cfg_data[sfde_pkg::ROW_W-1:0];
                sfde_pkg::REG_EDGE_THRESHOLD: r_threshold <= i_cfg_data[sfde_pkg::PIX_W-1:0];
                sfde_pkg::REG_AUTO_MODE:      r_auto      <= i_cfg_data[0];
            endcase
        end
    end

    // Cap the row length at the line store depth
    assign w_eff   = (r_width > sfde_pkg::WID_W'(sfde_pkg::MAX_WIDTH))
                   ? sfde_pkg::WID_W'(sfde_pkg::MAX_WIDTH) : r_width;
    assign col_inc = {1'b0, r_col} + sfde_pkg::WID_W'(1);
    assign row_inc = {1'b0, r_row} + (sfde_pkg::ROW_W+1)'(1);

    // Advance the raster position, wrap at row end and frame end
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            if (row_inc >= {1'b0, r_height}) begin
                n_row = '0;
            end else begin
                n_row = row_inc[sfde_pkg::ROW_W-1:0];
            end
        end else begin
            n_col = col_inc[sfde_pkg::COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Tag the incoming pixel with its window centre
    assign o_meta.has_res = (r_row >= sfde_pkg::ROW_W'(2)) && (r_col >= sfde_pkg::COL_W'(2));
    assign o_meta.row     = r_row - sfde_pkg::ROW_W'(1);
    assign o_meta.col     = r_col - sfde_pkg::COL_W'(1);
    assign o_meta.last    = (row_inc == {1'b0, r_height}) && (col_inc == w_eff);
    assign o_threshold    = r_threshold;
    assign o_auto_mode    = r_auto;

endmodule

FILE: hw/rtl/sfde_window.sv
module sfde_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [sfde_pkg::PIX_W-1:0] i_pixel,
    input  sfde_pkg::t_meta            i_meta,
    input  logic                       i_down_ready,
    output logic                       o_ready,
    output logic                       o_valid,
    output sfde_pkg::t_window          o_window,
    output sfde_pkg::t_meta            o_meta
);

    localparam int LW = 2 * sfde_pkg::PIX_W;

    // Line store entry: upper row in the high byte, middle row in the low byte
    logic [LW-1:0] r_line [sfde_pkg::MAX_WIDTH];

    logic                       r1_valid;
    logic [sfde_pkg::PIX_W-1:0] r1_px;
    logic [LW-1:0]              r1_rd;
    sfde_pkg::t_meta            r1_meta;

    logic                       r2_valid;
    sfde_pkg::t_window          r_win;
    sfde_pkg::t_meta            r2_meta;

    logic                       en1;
    logic                       en2;
    logic                       move;
    logic [LW-1:0]              wr_data;

    assign en2     = !r2_valid || i_down_ready;
    assign en1     = !r1_valid || en2;
    assign move    = r1_valid && en2;
    assign o_ready = en1;

    // Old middle moves up, new pixel becomes middle
    assign wr_data = {r1_rd[sfde_pkg::PIX_W-1:0], r1_px};

    // Line store write as the transaction leaves the read stage
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_line[r1_meta.col + sfde_pkg::COL_W'(1)] <= wr_data;
        end
    end

    // Read stage: forward a write to the same column in the same cycle
    always_ff @(posedge i_clk) begin
        if (en1 && i_accept) begin
            r1_px   <= i_pixel;
            r1_meta <= i_meta;
            if (move && (r1_meta.col == i_meta.col)) begin
                r1_rd <= wr_data;
            end else begin
                r1_rd <= r_line[i_meta.col + sfde_pkg::COL_W'(1)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_accept;
        end
    end

    // Window stage: shift left, load the new right column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (move) begin
            for (int k = 0; k < 3; k++) begin
                r_win[3*k]   <= r_win[3*k+1];
                r_win[3*k+1] <= r_win[3*k+2];
            end
            r_win[2] <= r1_rd[LW-1:sfde_pkg::PIX_W];
            r_win[5] <= r1_rd[sfde_pkg::PIX_W-1:0];
            r_win[8] <= r1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r2_meta <= r1_meta;
        end
    end

    // Drop border pixels here: only interior centres go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid && r1_meta.has_res;
        end
    end

    assign o_valid  = r2_valid;
    assign o_window = r_win;
    assign o_meta   = r2_meta;

endmodule

FILE: hw/rtl/sfde_grad.sv
module sfde_grad (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  sfde_pkg::t_window            i_window,
    input  sfde_pkg::t_meta              i_meta,
    input  logic [sfde_pkg::PIX_W-1:0]   i_threshold,
    input  logic                         i_auto_mode,
    output logic                         o_ready,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic                         o_edge_res,
    output logic [sfde_pkg::ROW_W-1:0]   o_center_row,
    output logic [sfde_pkg::COL_W-1:0]   o_center_col,
    output logic                         o_frame_last
);

    localparam int S3_W  = sfde_pkg::PIX_W + 2;
    localparam int SUM_W = sfde_pkg::PIX_W + 4;
    localparam int MUL_W = S3_W + 4;

    logic               r3_valid;
    logic [S3_W-1:0]    r3_max;
    logic [SUM_W-1:0]   r3_sum;
    sfde_pkg::t_meta    r3_meta;

    logic               r_out_valid;
    logic               r_out_edge;
    sfde_pkg::t_meta    r_out_meta;

    logic               en3;
    logic               en_out;
    logic [S3_W-1:0]    m0;
    logic [S3_W-1:0]    m1;
    logic [S3_W-1:0]    m2;
    logic [S3_W-1:0]    m3;
    logic [S3_W-1:0]    m01;
    logic [S3_W-1:0]    m23;
    logic [S3_W-1:0]    n_max;
    logic [SUM_W-1:0]   n_sum;
    logic [MUL_W-1:0]   max_x12;
    logic               n_edge;

    function automatic logic [S3_W-1:0] add3(input logic [sfde_pkg::PIX_W-1:0] x,
                                             input logic [sfde_pkg::PIX_W-1:0] y,
                                             input logic [sfde_pkg::PIX_W-1:0] z);
        return S3_W'(x) + S3_W'(y) + S3_W'(z);
    endfunction

    function automatic logic [S3_W-1:0] absdiff(input logic [S3_W-1:0] p,
                                                input logic [S3_W-1:0] q);
        return (p >= q) ? (p - q) : (q - p);
    endfunction

    assign en_out  = !r_out_valid || !i_stall;
    assign en3     = !r3_valid || en_out;
    assign o_ready = en3;

    // Four directional gradient magnitudes
    assign m0 = absdiff(add3(i_window[2], i_window[5], i_window[8]),
                        add3(i_window[0], i_window[3], i_window[6]));
    assign m1 = absdiff(add3(i_window[6], i_window[7], i_window[8]),
                        add3(i_window[0], i_window[1], i_window[2]));
    assign m2 = absdiff(add3(i_window[3], i_window[7], i_window[6]),
                        add3(i_window[1], i_window[5], i_window[2]));
    assign m3 = absdiff(add3(i_window[5], i_window[7], i_window[8]),
                        add3(i_window[1], i_window[3], i_window[0]));

    assign m01   = (m1 > m0) ? m1 : m0;
    assign m23   = (m3 > m2) ? m3 : m2;
    assign n_max = (m23 > m01) ? m23 : m01;

    // Window sum for the adaptive threshold
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < 9; k++) begin
            n_sum = n_sum + SUM_W'(i_window[k]);
        end
    end

    // Gradient stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && i_valid) begin
            r3_max  <= n_max;
            r3_sum  <= n_sum;
            r3_meta <= i_meta;
        end
    end

    // Decide: 12*max against the sum, or max against the fixed threshold
    assign max_x12 = (MUL_W'(r3_max) << 3) + (MUL_W'(r3_max) << 2);
    assign n_edge  = i_auto_mode ? (max_x12 > MUL_W'(r3_sum))
                                 : (r3_max > S3_W'(i_threshold));

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r3_valid) begin
            r_out_edge <= n_edge;
            r_out_meta <= r3_meta;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_res   = r_out_edge;
    assign o_center_row = r_out_meta.row;
    assign o_center_col = r_out_meta.col;
    assign o_frame_last = r_out_meta.last;

endmodule

FILE: hw/rtl/sobel_four_direction_edge.sv
// Four-direction edge marker over a raster pixel stream, from unweighted gradient sums.
// A result passes the line store read, window, gradient and output register stages
// in order once its centre's bottom-right pixel is accepted. Throughput: one pixel
// per cycle while i_stall is low; the line store takes one read and one write a cycle.
// Reset: synchronous, active low; clears counters, window, pipeline valids and
// loads the register defaults. The line store is not cleared.
module sobel_four_direction_edge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sfde_pkg::PIX_W-1:0]   i_pixel,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_edge_res,
    output logic [sfde_pkg::ROW_W-1:0]   o_center_row,
    output logic [sfde_pkg::COL_W-1:0]   o_center_col,
    output logic                         o_frame_last,
    input  logic                         i_cfg_we,
    input  logic [sfde_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [sfde_pkg::CFG_W-1:0]   i_cfg_data
);

    logic                       accept;
    logic                       win_ready;
    logic                       grad_ready;
    logic                       win_valid;
    sfde_pkg::t_meta            scan_meta;
    sfde_pkg::t_meta            win_meta;
    sfde_pkg::t_window          window;
    logic [sfde_pkg::PIX_W-1:0] threshold;
    logic                       auto_mode;

    // Take a transaction when the read stage has room
    assign o_stall = !win_ready;
    assign accept  = i_valid && win_ready;

    sfde_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_meta      (scan_meta),
        .o_threshold (threshold),
        .o_auto_mode (auto_mode)
    );

    sfde_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_pixel      (i_pixel),
        .i_meta       (scan_meta),
        .i_down_ready (grad_ready),
        .o_ready      (win_ready),
        .o_valid      (win_valid),
        .o_window     (window),
        .o_meta       (win_meta)
    );

    sfde_grad u_grad (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (win_valid),
        .i_window     (window),
        .i_meta       (win_meta),
        .i_threshold  (threshold),
        .i_auto_mode  (auto_mode),
        .o_ready      (grad_ready),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_edge_res   (o_edge_res),
        .o_center_row (o_center_row),
        .o_center_col (o_center_col),
        .o_frame_last (o_frame_last)
    );

endmodule
